### src/ntpc_pkg.sv
// package for the nearest target pursuit controller
// widths, codes and the cordic arctangent table; no dependencies
package ntpc_pkg;

    localparam int COORD_W = 16;
    localparam int ANGLE_W = 16;
    localparam int GAIN_W = 12;
    localparam int RAD_W = 15;
    localparam int ID_W = 8;
    localparam int VEL_W = 24;
    localparam int CMD_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam int ENTRY_W = 2 * COORD_W + ID_W;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_CORDIC_ITERATIONS = 16;

    localparam logic [CMD_W-1:0] CMD_TARGET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CATCH_RADIUS = 2'd2;

    // cordic working width: 17 bit offset, 16 guard bits, growth
    localparam int CW = 36;
    localparam int ZW = 18;
    localparam logic signed [ZW-1:0] PI_Q13 = 18'sd25736;
    localparam logic signed [ZW-1:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic [15:0] INV_K_Q16 = 16'd39796;

    typedef struct packed {
        logic start_search;
        logic start_cordic;
        logic load_held;
        logic start_out;
    } t_ctrl;

    typedef struct packed {
        logic search_done;
        logic cordic_done;
        logic out_done;
    } t_stat;

    function automatic logic signed [ZW-1:0] atan_q13(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        begin
            unique case (i)
                5'd0: v = 18'sd6434;
                5'd1: v = 18'sd3798;
                5'd2: v = 18'sd2007;
                5'd3: v = 18'sd1019;
                5'd4: v = 18'sd511;
                5'd5: v = 18'sd256;
                5'd6: v = 18'sd128;
                5'd7: v = 18'sd64;
                5'd8: v = 18'sd32;
                5'd9: v = 18'sd16;
                5'd10: v = 18'sd8;
                5'd11: v = 18'sd4;
                5'd12: v = 18'sd2;
                5'd13: v = 18'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [47:0] v);
        logic signed [VEL_W-1:0] r;
        begin
            if (v > 48'sd8388607) r = 24'sh7FFFFF;
            else if (v < -48'sd8388608) r = 24'sh800000;
            else r = v[VEL_W-1:0];
            return r;
        end
    endfunction

endpackage

### src/ntpc_ram.sv
// generic simple dual port ram with separate read and write addresses, registered read
// no dependencies
module ntpc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/ntpc_datapath.sv
// datapath: target table, pose, nearest search, cordic, velocity output
// depends on ntpc_pkg and ntpc_ram
module ntpc_datapath
    import ntpc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_take,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    input  logic signed [ANGLE_W-1:0] i_hd,
    input  logic [ID_W-1:0]           i_id,
    input  logic                      i_ev,
    input  logic                      i_ll,
    input  t_ctrl                     i_ctrl,
    input  logic                      i_out_stall,
    output t_stat                     o_stat,
    output logic                      o_pose_seen,
    output logic                      o_held,
    output logic                      o_count_zero,
    output logic                      o_valid,
    output logic signed [VEL_W-1:0]   o_lin,
    output logic signed [VEL_W-1:0]   o_ang,
    output logic                      o_req,
    output logic [ID_W-1:0]           o_cid,
    output logic                      o_last
);
    localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IT_W = $clog2(CORDIC_ITERATIONS + 1);

    logic [GAIN_W-1:0] r_ag, r_dg;
    logic [RAD_W-1:0] r_rad;
    logic [CNT_W-1:0] r_count, r_load;
    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic signed [ANGLE_W-1:0] r_oh;
    logic r_pose, r_held;
    logic [ENTRY_W-1:0] r_htgt;
    logic r_fin_catch;

    // table write and read
    logic tbl_we;
    logic [AW-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    assign tbl_we = i_take && i_cmd == CMD_TARGET && i_ev && r_load < CNT_W'(TABLE_DEPTH);

    ntpc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl (
        .i_clk(i_clk), .i_we(tbl_we), .i_waddr(r_load[AW-1:0]),
        .i_wdata({i_x, i_y, i_id}), .i_raddr(rd_addr), .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ag <= 12'd1536; r_dg <= 12'd512; r_rad <= 15'd1024;
            r_count <= '0; r_load <= '0; r_ox <= '0; r_oy <= '0; r_oh <= '0;
            r_pose <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ANGLE_GAIN: r_ag <= i_cfg_data[GAIN_W-1:0];
                    CFG_DIST_GAIN: r_dg <= i_cfg_data[GAIN_W-1:0];
                    CFG_CATCH_RADIUS: r_rad <= i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_take && i_cmd == CMD_TARGET) begin
                if (i_ll) begin
                    r_count <= tbl_we ? r_load + 1'b1 : r_load;
                    r_load <= '0;
                end else if (tbl_we) begin
                    r_load <= r_load + 1'b1;
                end
            end
            if (i_take && i_cmd == CMD_POSE) begin
                r_ox <= i_x; r_oy <= i_y; r_oh <= i_hd; r_pose <= 1'b1;
            end
        end
    end

    assign o_pose_seen = r_pose;
    assign o_held = r_held;
    assign o_count_zero = r_count == '0;

    // nearest search: issue address, compare in the next cycle
    logic r_srch, r_cmp_v, r_sdone;
    logic [CNT_W-1:0] r_si, r_ci;
    logic [34:0] r_bestd;
    logic [ENTRY_W-1:0] r_bent;
    logic signed [COORD_W:0] ex, ey;
    logic [34:0] dd;
    assign rd_addr = r_si[AW-1:0];
    assign ex = {rd_data[ENTRY_W-1], rd_data[ENTRY_W-1 -: COORD_W]} - {r_ox[COORD_W-1], r_ox};
    assign ey = {rd_data[ID_W+COORD_W-1], rd_data[ID_W +: COORD_W]} - {r_oy[COORD_W-1], r_oy};
    assign dd = 35'(ex * ex) + 35'(ey * ey);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srch <= 1'b0; r_cmp_v <= 1'b0; r_sdone <= 1'b0;
        end else begin
            r_cmp_v <= r_srch;
            // done once the last compare has landed in r_bent
            r_sdone <= r_cmp_v && !r_srch;
            if (i_ctrl.start_search) begin
                r_srch <= 1'b1; r_si <= '0;
            end else if (r_srch) begin
                r_ci <= r_si;
                if (r_si + 1'b1 >= r_count) r_srch <= 1'b0;
                r_si <= r_si + 1'b1;
            end
            if (r_cmp_v && (r_ci == '0 || dd < r_bestd)) begin
                r_bestd <= dd; r_bent <= rd_data;
            end
        end
    end
    assign o_stat.search_done = r_sdone;

    // cordic vectoring, one step a cycle
    logic r_cor;
    logic [IT_W-1:0] r_it;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic signed [COORD_W:0] hx, hy;
    logic signed [CW-1:0] sx, sy;
    assign hx = {r_htgt[ENTRY_W-1], r_htgt[ENTRY_W-1 -: COORD_W]} - {r_ox[COORD_W-1], r_ox};
    assign hy = {r_htgt[ID_W+COORD_W-1], r_htgt[ID_W +: COORD_W]} - {r_oy[COORD_W-1], r_oy};
    assign sx = r_cx >>> r_it;
    assign sy = r_cy >>> r_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0; r_cor <= 1'b0;
        end else begin
            if (i_ctrl.load_held) begin
                r_htgt <= r_bent; r_held <= 1'b1;
            end
            if (i_ctrl.start_cordic) begin
                r_cor <= 1'b1; r_it <= '0;
                if (hx < 0) begin
                    r_cx <= -(CW'(hx) <<< 16); r_cy <= -(CW'(hy) <<< 16);
                    r_cz <= (hy >= 0) ? PI_Q13 : -PI_Q13;
                end else begin
                    r_cx <= CW'(hx) <<< 16; r_cy <= CW'(hy) <<< 16; r_cz <= '0;
                end
                if (hx == 0 && hy == 0) r_cor <= 1'b0;
            end else if (r_cor) begin
                if (r_cy >= 0) begin
                    r_cx <= r_cx + sy; r_cy <= r_cy - sx; r_cz <= r_cz + atan_q13(5'(r_it));
                end else begin
                    r_cx <= r_cx - sy; r_cy <= r_cy + sx; r_cz <= r_cz - atan_q13(5'(r_it));
                end
                r_it <= r_it + 1'b1;
                if (r_it == IT_W'(CORDIC_ITERATIONS - 1)) r_cor <= 1'b0;
            end
            if (i_ctrl.start_out && r_fin_catch) r_held <= 1'b0;
        end
    end
    logic r_cor_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cor_q <= 1'b0;
        else r_cor_q <= i_ctrl.start_cordic || r_cor;
    end
    assign o_stat.cordic_done = r_cor_q && !r_cor && !i_ctrl.start_cordic;

    // post stages: distance, error, products
    logic [2:0] r_ph;
    logic signed [CW-1:0] r_dist;
    logic signed [ZW:0] r_err;
    logic signed [47:0] r_plin, r_pang;
    logic signed [ZW:0] e0;
    logic signed [CW+17:0] xm;
    assign e0 = (ZW+1)'(r_cz) - (ZW+1)'(r_oh);
    assign xm = (CW+18)'(r_cx) * $signed({2'b0, INV_K_Q16}) + (CW+18)'(64'sd2147483648);

    // output register
    logic r_ov;
    logic r_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0; r_ov <= 1'b0; r_pend <= 1'b0; r_fin_catch <= 1'b0;
        end else begin
            if (o_stat.cordic_done && r_ph == '0) begin
                r_ph <= 3'd1;
                r_dist <= (r_cx == '0 && r_cy == '0 && r_cz == '0) ? '0 : CW'(xm >>> 32);
                r_err <= (e0 > PI_Q13) ? e0 - TWO_PI_Q13 :
                         (e0 < -PI_Q13) ? e0 + TWO_PI_Q13 : e0;
            end else if (r_ph == 3'd1) begin
                r_ph <= 3'd2;
                r_plin <= 48'($signed({1'b0, r_dg})) * 48'(r_dist) + 48'sd256;
                r_pang <= 48'($signed({1'b0, r_ag})) * 48'(r_err) + 48'sd1024;
                r_fin_catch <= r_dist < $signed({1'b0, r_rad});
            end else if (r_ph == 3'd2) begin
                r_ph <= 3'd3;
            end
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            if (i_ctrl.start_out) begin
                r_ov <= 1'b1; r_ph <= '0;
                o_lin <= sat_vel(r_plin >>> 9);
                o_ang <= sat_vel(r_pang >>> 11);
                o_req <= 1'b0; o_cid <= '0; o_last <= !r_fin_catch;
                r_pend <= r_fin_catch;
            end else if (r_pend && r_ov && !i_out_stall) begin
                r_ov <= 1'b1; r_pend <= 1'b0;
                o_lin <= '0; o_ang <= '0; o_req <= 1'b1;
                o_cid <= r_htgt[ID_W-1:0]; o_last <= 1'b1;
            end
        end
    end
    assign o_valid = r_ov;
    assign o_stat.out_done = r_ph == 3'd3;
endmodule

### src/ntpc_ctrl.sv
// controller state machine sequencing search, cordic and output
// depends on ntpc_pkg
module ntpc_ctrl
    import ntpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_pose_seen,
    input  logic             i_held,
    input  logic             i_count_zero,
    input  logic             i_out_busy,
    input  t_stat            i_stat,
    output logic             o_stall,
    output t_ctrl            o_ctrl
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_CORD = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_DRN = 3'd4;

    logic [2:0] r_state, n_state;
    logic take_tick;

    assign o_stall = r_state != S_IDLE || i_out_busy;
    assign take_tick = i_valid && !o_stall && i_cmd == CMD_TICK && i_pose_seen;

    always_comb begin
        n_state = r_state;
        o_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (take_tick) begin
                    if (i_held) begin
                        o_ctrl.start_cordic = 1'b1; n_state = S_CORD;
                    end else if (!i_count_zero) begin
                        o_ctrl.start_search = 1'b1; n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: if (i_stat.search_done) begin
                o_ctrl.load_held = 1'b1; n_state = S_DRN;
            end
            S_DRN: begin
                o_ctrl.start_cordic = 1'b1; n_state = S_CORD;
            end
            S_CORD: if (i_stat.cordic_done) n_state = S_POST;
            S_POST: if (i_stat.out_done) begin
                o_ctrl.start_out = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

### src/nearest_target_pursuit_controller.sv
// top level of the nearest target pursuit controller
// depends on ntpc_pkg, ntpc_ctrl, ntpc_datapath
//
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  cmd, coords, heading, id, flags
// result    out        o_valid / i_stall  speeds, catch request, id, last
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// target and pose beats are accepted whenever stall is low
// a tick runs the one-entry-a-cycle table scan and then the one-step-a-cycle
// cordic loop before its first result beat; the scan is skipped when a target
// is held
// stall stays high while a tick is worked on or a result beat is pending
// synchronous active low reset clears pose, list and held target, and sets gains and catch radius to defaults
module nearest_target_pursuit_controller
    import ntpc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic signed [ANGLE_W-1:0] i_heading,
    input  logic [ID_W-1:0]           i_target_id,
    input  logic                      i_entry_valid,
    input  logic                      i_list_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VEL_W-1:0]   o_fwd_speed,
    output logic signed [VEL_W-1:0]   o_turn_rate,
    output logic                      o_catch_request,
    output logic [ID_W-1:0]           o_catch_id,
    output logic                      o_last
);
    t_ctrl ctrl;
    t_stat stat;
    logic pose_seen, held, count_zero;

    // results are pending until every beat of a tick has left
    ntpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_cmd(i_cmd),
        .i_pose_seen(pose_seen), .i_held(held), .i_count_zero(count_zero),
        .i_out_busy(o_valid), .i_stat(stat), .o_stall(o_stall), .o_ctrl(ctrl)
    );

    ntpc_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_take(i_valid && !o_stall), .i_cmd(i_cmd),
        .i_x(i_x_coord), .i_y(i_y_coord), .i_hd(i_heading), .i_id(i_target_id),
        .i_ev(i_entry_valid), .i_ll(i_list_last), .i_ctrl(ctrl), .i_out_stall(i_stall),
        .o_stat(stat), .o_pose_seen(pose_seen), .o_held(held), .o_count_zero(count_zero),
        .o_valid(o_valid), .o_lin(o_fwd_speed), .o_ang(o_turn_rate),
        .o_req(o_catch_request), .o_cid(o_catch_id), .o_last(o_last)
    );
endmodule

### src/ntpc_checker.sv
// port level checks for the pursuit controller, bound to the top level
// depends on ntpc_pkg
module ntpc_port_props
    import ntpc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_catch_request,
    input logic o_last,
    input logic signed [VEL_W-1:0] o_fwd_speed
);
    a_catch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_catch_request |-> o_last) else $error("catch beat not last");
    a_catch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_catch_request |-> o_fwd_speed == '0) else $error("catch speed");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");
endmodule

bind nearest_target_pursuit_controller ntpc_port_props u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_catch_request(o_catch_request),
    .o_last(o_last), .o_fwd_speed(o_fwd_speed)
);
